[src/epu_pkg.sv]
`default_nettype none

package epu_pkg;

  // Stream payload widths, packed from the lowest bit up
  localparam int IN_W  = 56;
  localparam int OUT_W = 240;

  // Angles are held in units of 1/128 degree
  localparam int ANG_HALF    = 23040;
  localparam int ANG_FULL    = 46080;
  localparam int ANG_QUARTER = 11520;
  localparam int PITCH_LIMIT = 11392;
  // Offset that makes the unwrapped angle sum non-negative: half turn plus 256 turns
  localparam int ANG_BIAS    = 11819520;
  localparam int RED_STEPS   = 8;

  localparam int CORDIC_GAIN = 652032874;
  localparam int Q14_ONE     = 16384;

  // Configuration register indexes
  localparam logic REG_MOVE_SPEED = 1'b0;
  localparam logic REG_LOOK_SENS  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK_MUL,
    ST_LOOK_ADD,
    ST_LOOK_RED,
    ST_LOOK_WR,
    ST_VEL_MUL,
    ST_VEL_GET,
    ST_MOVE_MUL,
    ST_MOVE_ADD,
    ST_TRIG_YAW,
    ST_WAIT_YAW,
    ST_TRIG_PITCH,
    ST_WAIT_PITCH,
    ST_BAS_MUL,
    ST_BAS_USE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_rsp_t;

  // Arctangent of 2^-i in degrees * 65536
  function automatic logic [22:0] atan_deg(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0:    r = 23'd2949120;
      5'd1:    r = 23'd1740967;
      5'd2:    r = 23'd919879;
      5'd3:    r = 23'd466945;
      5'd4:    r = 23'd234379;
      5'd5:    r = 23'd117304;
      5'd6:    r = 23'd58666;
      5'd7:    r = 23'd29335;
      5'd8:    r = 23'd14668;
      5'd9:    r = 23'd7334;
      5'd10:   r = 23'd3667;
      5'd11:   r = 23'd1833;
      5'd12:   r = 23'd917;
      5'd13:   r = 23'd458;
      5'd14:   r = 23'd229;
      5'd15:   r = 23'd115;
      5'd16:   r = 23'd57;
      5'd17:   r = 23'd29;
      5'd18:   r = 23'd14;
      5'd19:   r = 23'd7;
      5'd20:   r = 23'd4;
      5'd21:   r = 23'd2;
      5'd22:   r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // Round a Q2.30 value half up to Q2.14 and clamp it to plus or minus one
  function automatic logic signed [15:0] q14_sat(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + 36'sd32768) >>> 16;
    if (r > 36'sd16384) begin
      r = 36'sd16384;
    end else if (r < -36'sd16384) begin
      r = -36'sd16384;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

[src/epu_mul.sv]
`default_nettype none

module epu_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      prod
);

  // Shared signed multiplier with its product registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

[src/epu_cordic.sv]
`default_nettype none

module epu_cordic #(
  parameter int Iterations = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire epu_pkg::cordic_req_t req,
  output epu_pkg::cordic_rsp_t rsp
);

  import epu_pkg::*;

  localparam int IW = (Iterations > 1) ? $clog2(Iterations) : 1;

  logic                busy;
  logic                done;
  logic                neg;
  logic [IW-1:0]       iter;
  logic signed [32:0]  x;
  logic signed [32:0]  y;
  logic signed [26:0]  z;

  logic signed [16:0]  a_in;
  logic signed [16:0]  a_fold;
  logic                fold;
  logic signed [32:0]  dx;
  logic signed [32:0]  dy;
  logic signed [26:0]  at;

  // Fold the angle into plus or minus 90 degrees
  always_comb begin
    a_in = 17'(req.angle);
    fold = 1'b0;
    a_fold = a_in;
    if (a_in > 17'sd11520) begin
      a_fold = a_in - 17'(ANG_HALF);
      fold = 1'b1;
    end else if (a_in < -17'sd11520) begin
      a_fold = a_in + 17'(ANG_HALF);
      fold = 1'b1;
    end
  end

  // One micro-rotation per cycle
  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign at = signed'({4'b0, atan_deg(5'(iter))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
        neg  <= fold;
        x    <= 33'(CORDIC_GAIN);
        y    <= '0;
        z    <= 27'(a_fold) <<< 9;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (iter == IW'(Iterations - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  // Results are negated when the angle was folded
  always_comb begin
    rsp.done  = done;
    rsp.cos_v = neg ? 32'(-x) : 32'(x);
    rsp.sin_v = neg ? 32'(-y) : 32'(y);
  end

endmodule

`default_nettype wire

[src/euler_camera_pose_update.sv]
`default_nettype none

// Fly camera pose unit. Each input transaction is either a look update (tuser 0: mouse
// deltas turn yaw and pitch, both wrapping at 180 degrees, pitch optionally held within
// 89 degrees) or a move update (tuser 1: six key bits step the position along the
// current basis by speed times time step, five times that under boost). Every
// transaction returns one output transaction with the rebuilt forward, right and up
// vectors in Q2.14 and the position in Q24.8. The block takes one transaction at a
// time; s_axis_tready is low until the result has been loaded into the output register.
// The one CORDIC unit computes yaw and then pitch at one rotation per cycle, the single
// shared multiplier serves the angle, velocity, position and basis products one after
// another, and each angle goes through a nine-step modulo reduction.
module euler_camera_pose_update #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_index,
  input  wire logic [15:0]              cfg_data,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // look_dx, look_dy, clamp_pitch, move_keys, boost, time_step
  input  wire logic [epu_pkg::IN_W-1:0] s_axis_tdata,
  // mode
  input  wire logic                     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // fwd_x, fwd_y, fwd_z, side_x, side_y, side_z, top_x, top_y, top_z, pos_x, pos_y, pos_z
  output logic [epu_pkg::OUT_W-1:0]     m_axis_tdata
);

  import epu_pkg::*;

  state_t state;
  state_t state_next;

  logic [15:0]        move_speed;
  logic [15:0]        look_sensitivity;
  logic signed [15:0] yaw;
  logic signed [15:0] pitch;
  logic signed [31:0] pos  [3];
  logic signed [15:0] fwd  [3];
  logic signed [15:0] side [3];
  logic signed [15:0] top  [3];

  // Latched input transaction
  logic               mode;
  logic signed [15:0] look_dx;
  logic signed [15:0] look_dy;
  logic               clamp_pitch;
  logic [5:0]         move_keys;
  logic               boost;
  logic [15:0]        time_step;

  // Sequencer and datapath registers
  logic               ax;
  logic [3:0]         cnt;
  logic [1:0]         k;
  logic [2:0]         bstep;
  logic [24:0]        rr;
  logic [31:0]        vel;
  logic signed [31:0] cy;
  logic signed [31:0] sy;
  logic signed [31:0] cp;
  logic signed [31:0] sp;
  logic signed [31:0] fx;
  logic signed [31:0] fz;
  logic signed [65:0] tmp;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  cordic_req_t        creq;
  cordic_rsp_t        crsp;

  logic               in_fire;
  logic signed [32:0] rx;
  logic signed [32:0] rz;
  logic signed [18:0] axis_sum;
  logic signed [65:0] look_sum;
  logic signed [25:0] delta;
  logic signed [15:0] ang_cur;
  logic signed [26:0] ang_biased;
  logic [24:0]        thr;
  logic signed [16:0] ang_wide;
  logic signed [15:0] ang_new;
  logic signed [65:0] acc;
  logic signed [65:0] acc_r;
  logic signed [39:0] psum;
  logic signed [31:0] psat;
  logic signed [65:0] pr;
  logic signed [65:0] nr;
  logic signed [65:0] dr;

  epu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  epu_cordic #(
    .Iterations (TRIG_ITERATIONS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Right vector follows the sign of cos pitch; zero counts as positive
  assign rx = (cp >= 0) ? -33'(sy) : 33'(sy);
  assign rz = (cp >= 0) ? 33'(cy) : -33'(cy);

  // Signed sum of the basis components selected by the keys on the current axis
  always_comb begin
    axis_sum = '0;
    if (move_keys[0]) axis_sum = axis_sum + 19'(fwd[k]);
    if (move_keys[1]) axis_sum = axis_sum - 19'(fwd[k]);
    if (move_keys[2]) axis_sum = axis_sum - 19'(side[k]);
    if (move_keys[3]) axis_sum = axis_sum + 19'(side[k]);
    if (move_keys[4]) axis_sum = axis_sum + 19'(top[k]);
    if (move_keys[5]) axis_sum = axis_sum - 19'(top[k]);
  end

  // Angle update: round the scaled delta and bias the sum to be non-negative
  always_comb begin
    look_sum   = prod + 66'sd256;
    delta      = signed'(look_sum[34:9]);
    ang_cur    = ax ? pitch : yaw;
    ang_biased = 27'(ang_cur) + 27'(delta) + 27'(ANG_BIAS);
    thr        = 25'(ANG_FULL) << cnt;
    ang_wide   = signed'({1'b0, rr[15:0]}) - 17'(ANG_HALF);
    ang_new    = ang_wide[15:0];
    if (ax && clamp_pitch) begin
      if (ang_new > 16'(PITCH_LIMIT)) begin
        ang_new = 16'(PITCH_LIMIT);
      end else if (ang_new < -16'(PITCH_LIMIT)) begin
        ang_new = -16'(PITCH_LIMIT);
      end
    end
  end

  // Position step with saturation
  always_comb begin
    acc   = boost ? (prod <<< 2) + prod : prod;
    acc_r = (acc + (66'sd1 <<< 29)) >>> 30;
    psum  = 40'(pos[k]) + signed'(acc_r[39:0]);
    if (psum > 40'sd2147483647) begin
      psat = 32'sh7FFFFFFF;
    end else if (psum < -40'sd2147483648) begin
      psat = 32'sh80000000;
    end else begin
      psat = psum[31:0];
    end
  end

  // Rounded basis products
  assign pr = (prod + (66'sd1 <<< 29)) >>> 30;
  assign nr = (-prod + (66'sd1 <<< 29)) >>> 30;
  assign dr = ((tmp - prod) + (66'sd1 <<< 29)) >>> 30;

  // Next state, multiplier operands and CORDIC requests
  always_comb begin
    state_next    = state;
    s_axis_tready = (state == ST_IDLE);
    mul_a         = '0;
    mul_b         = '0;
    creq.start    = 1'b0;
    creq.angle    = yaw;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = s_axis_tuser ? ST_VEL_MUL : ST_LOOK_MUL;
        end
      end
      ST_LOOK_MUL: begin
        mul_a      = 33'(ax ? look_dy : look_dx);
        mul_b      = signed'({17'b0, look_sensitivity});
        state_next = ST_LOOK_ADD;
      end
      ST_LOOK_ADD: begin
        state_next = ST_LOOK_RED;
      end
      ST_LOOK_RED: begin
        if (cnt == '0) begin
          state_next = ST_LOOK_WR;
        end
      end
      ST_LOOK_WR: begin
        state_next = ax ? ST_TRIG_YAW : ST_LOOK_MUL;
      end
      ST_VEL_MUL: begin
        mul_a      = signed'({17'b0, move_speed});
        mul_b      = signed'({17'b0, time_step});
        state_next = ST_VEL_GET;
      end
      ST_VEL_GET: begin
        state_next = ST_MOVE_MUL;
      end
      ST_MOVE_MUL: begin
        mul_a      = 33'(axis_sum);
        mul_b      = signed'({1'b0, vel});
        state_next = ST_MOVE_ADD;
      end
      ST_MOVE_ADD: begin
        state_next = (k == 2'd2) ? ST_TRIG_YAW : ST_MOVE_MUL;
      end
      ST_TRIG_YAW: begin
        creq.start = 1'b1;
        creq.angle = yaw;
        state_next = ST_WAIT_YAW;
      end
      ST_WAIT_YAW: begin
        if (crsp.done) begin
          state_next = ST_TRIG_PITCH;
        end
      end
      ST_TRIG_PITCH: begin
        creq.start = 1'b1;
        creq.angle = pitch;
        state_next = ST_WAIT_PITCH;
      end
      ST_WAIT_PITCH: begin
        if (crsp.done) begin
          state_next = ST_BAS_MUL;
        end
      end
      ST_BAS_MUL: begin
        case (bstep)
          3'd0: begin
            mul_a = 33'(cy);
            mul_b = 33'(cp);
          end
          3'd1: begin
            mul_a = 33'(sy);
            mul_b = 33'(cp);
          end
          3'd2: begin
            mul_a = rz;
            mul_b = 33'(sp);
          end
          3'd3: begin
            mul_a = rz;
            mul_b = 33'(fx);
          end
          3'd4: begin
            mul_a = rx;
            mul_b = 33'(fz);
          end
          default: begin
            mul_a = rx;
            mul_b = 33'(sp);
          end
        endcase
        state_next = ST_BAS_USE;
      end
      ST_BAS_USE: begin
        state_next = (bstep == 3'd5) ? ST_OUT : ST_BAS_MUL;
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed       <= 16'd640;
      look_sensitivity <= 16'd6554;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_MOVE_SPEED) begin
        move_speed <= cfg_data;
      end else if (cfg_index == REG_LOOK_SENS) begin
        look_sensitivity <= cfg_data;
      end
    end
  end

  // Latch the accepted input transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode        <= s_axis_tuser;
      look_dx     <= signed'(s_axis_tdata[15:0]);
      look_dy     <= signed'(s_axis_tdata[31:16]);
      clamp_pitch <= s_axis_tdata[32];
      move_keys   <= s_axis_tdata[38:33];
      boost       <= s_axis_tdata[39];
      time_step   <= s_axis_tdata[55:40];
    end
  end

  // Pose state and sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw     <= '0;
      pitch   <= '0;
      ax      <= 1'b0;
      k       <= '0;
      cnt     <= '0;
      bstep   <= '0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
      end
      fwd[0]  <= 16'(Q14_ONE);
      fwd[1]  <= '0;
      fwd[2]  <= '0;
      side[0] <= '0;
      side[1] <= '0;
      side[2] <= 16'(Q14_ONE);
      top[0]  <= '0;
      top[1]  <= 16'(Q14_ONE);
      top[2]  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          ax    <= 1'b0;
          k     <= '0;
          bstep <= '0;
        end
        ST_LOOK_ADD: begin
          rr  <= ang_biased[24:0];
          cnt <= 4'(RED_STEPS);
        end
        ST_LOOK_RED: begin
          if (rr >= thr) begin
            rr <= rr - thr;
          end
          if (cnt != '0) begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_LOOK_WR: begin
          if (ax) begin
            pitch <= ang_new;
          end else begin
            yaw <= ang_new;
          end
          ax <= 1'b1;
        end
        ST_VEL_GET: begin
          vel <= prod[31:0];
        end
        ST_MOVE_ADD: begin
          pos[k] <= psat;
          k      <= k + 1'b1;
        end
        ST_WAIT_YAW: begin
          if (crsp.done) begin
            cy <= crsp.cos_v;
            sy <= crsp.sin_v;
          end
        end
        ST_WAIT_PITCH: begin
          if (crsp.done) begin
            cp <= crsp.cos_v;
            sp <= crsp.sin_v;
          end
          bstep <= '0;
        end
        ST_BAS_USE: begin
          case (bstep)
            3'd0: fx <= pr[31:0];
            3'd1: fz <= pr[31:0];
            3'd2: top[0] <= q14_sat(signed'(nr[35:0]));
            3'd3: tmp <= prod;
            3'd4: top[1] <= q14_sat(signed'(dr[35:0]));
            default: begin
              top[2]  <= q14_sat(signed'(pr[35:0]));
              fwd[0]  <= q14_sat(36'(fx));
              fwd[1]  <= q14_sat(36'(sp));
              fwd[2]  <= q14_sat(36'(fz));
              side[0] <= q14_sat(36'(rx));
              side[1] <= '0;
              side[2] <= q14_sat(36'(rz));
            end
          endcase
          bstep <= bstep + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds a result while the next transaction is taken in
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {pos[2], pos[1], pos[0],
                       top[2], top[1], top[0],
                       side[2], side[1], side[0],
                       fwd[2], fwd[1], fwd[0]};
    end
  end

  // The mode bit only steers the state at acceptance; keep it for debug visibility
  logic mode_move_seen;
  assign mode_move_seen = mode && (state == ST_VEL_MUL);

  // Checks
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    (yaw >= -16'sd23040) && (yaw <= 16'sd23039))
    else $error("yaw left its wrapped range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input taken while a transaction is in progress");

  a_cordic_done_wait: assert property (@(posedge clk) disable iff (rst)
    crsp.done |-> (state == ST_WAIT_YAW || state == ST_WAIT_PITCH))
    else $error("trig result arrived outside a wait state");

  a_move_path: assert property (@(posedge clk) disable iff (rst)
    mode_move_seen |=> (state == ST_VEL_GET))
    else $error("move transaction left the velocity step");

  a_fwd_bound: assert property (@(posedge clk) disable iff (rst)
    (fwd[0] <= 16'sd16384) && (fwd[0] >= -16'sd16384))
    else $error("forward x out of Q2.14 range");

endmodule

`default_nettype wire

[sim/euler_camera_pose_update_test.sv]
`timescale 1ns / 100ps

module euler_camera_pose_update_test;
  import epu_pkg::*;

  localparam int TRIG_ITER   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 120;

  // Move key bits
  localparam int KEY_FWD   = 0;
  localparam int KEY_BACK  = 1;
  localparam int KEY_LEFT  = 2;
  localparam int KEY_RIGHT = 3;
  localparam int KEY_UP    = 4;
  localparam int KEY_DOWN  = 5;

  typedef enum bit {MODE_LOOK = 1'b0, MODE_MOVE = 1'b1} mode_t;

  typedef struct {
    mode_t              mode;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               clamp;
    logic [5:0]         keys;
    logic               boost;
    logic [15:0]        tstep;
    bit                 pos_at_origin;
  } cam_item_t;

  typedef struct {
    logic signed [15:0] vec [9];
    logic signed [31:0] pos [3];
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  euler_camera_pose_update #(.TRIG_ITERATIONS(TRIG_ITER)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Own copy of the camera state and registers
  longint speed_q8, sens_q16;
  longint yaw_ang, pitch_ang;
  longint cam_pos [3];
  longint cam_basis [9];

  pose_t pending_poses [$];
  int    fail_count = 0;
  int    cycle_count = 0;
  bit    calm_src = 1'b0;
  bit    calm_sink = 1'b0;

  // Result field names, in packing order
  const string vec_names [9] = '{"fwd_x", "fwd_y", "fwd_z", "side_x", "side_y", "side_z",
                                 "top_x", "top_y", "top_z"};
  const string pos_names [3] = '{"pos_x", "pos_y", "pos_z"};

  const longint atan_steps [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint round_shift(input longint v, input int s);
    longint one;
    one = 1;
    return (v + (one <<< (s - 1))) >>> s;
  endfunction

  function automatic longint q14_clamp(input longint v);
    longint r;
    r = round_shift(v, 16);
    if (r > Q14_ONE) r = Q14_ONE;
    if (r < -Q14_ONE) r = -Q14_ONE;
    return r;
  endfunction

  function automatic longint wrap_turn(input longint v);
    longint r;
    r = (v + ANG_HALF) % ANG_FULL;
    if (r < 0) r += ANG_FULL;
    return r - ANG_HALF;
  endfunction

  // Rotation-based cosine and sine of an angle in 1/128 degree, Q2.30 out
  task automatic cos_sin(input longint a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit folded;
    folded = 1'b0;
    x = CORDIC_GAIN;
    y = 0;
    if (a > ANG_QUARTER) begin
      a -= ANG_HALF;
      folded = 1'b1;
    end else if (a < -ANG_QUARTER) begin
      a += ANG_HALF;
      folded = 1'b1;
    end
    z = a * 512;
    for (int i = 0; i < TRIG_ITER && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    c = folded ? -x : x;
    s = folded ? -y : y;
  endtask

  task automatic rebuild_cam_basis();
    longint cy, sy, cp, sp, fx, fy, fz, rx, rz;
    cos_sin(yaw_ang, cy, sy);
    cos_sin(pitch_ang, cp, sp);
    fx = round_shift(cy * cp, 30);
    fy = sp;
    fz = round_shift(sy * cp, 30);
    // A cos pitch of exactly zero keeps the right vector unflipped
    if (cp >= 0) begin
      rx = -sy; rz = cy;
    end else begin
      rx = sy; rz = -cy;
    end
    cam_basis[0] = q14_clamp(fx);
    cam_basis[1] = q14_clamp(fy);
    cam_basis[2] = q14_clamp(fz);
    cam_basis[3] = q14_clamp(rx);
    cam_basis[4] = 0;
    cam_basis[5] = q14_clamp(rz);
    cam_basis[6] = q14_clamp(round_shift(-rz * fy, 30));
    cam_basis[7] = q14_clamp(round_shift(rz * fx - rx * fz, 30));
    cam_basis[8] = q14_clamp(round_shift(rx * fy, 30));
  endtask

  // Apply one item to the held state and return the pose it produces
  task automatic advance_pose(input cam_item_t it, output pose_t p);
    longint vel, acc, np;
    if (it.mode == MODE_LOOK) begin
      yaw_ang = wrap_turn(yaw_ang + round_shift(longint'(it.dx) * sens_q16, 9));
      pitch_ang = wrap_turn(pitch_ang + round_shift(longint'(it.dy) * sens_q16, 9));
      if (it.clamp) begin
        if (pitch_ang > PITCH_LIMIT) pitch_ang = PITCH_LIMIT;
        if (pitch_ang < -PITCH_LIMIT) pitch_ang = -PITCH_LIMIT;
      end
    end else begin
      vel = speed_q8 * longint'({48'd0, it.tstep});
      if (it.boost) vel *= 5;
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        if (it.keys[KEY_FWD])   acc += cam_basis[k] * vel;
        if (it.keys[KEY_BACK])  acc -= cam_basis[k] * vel;
        if (it.keys[KEY_LEFT])  acc -= cam_basis[3 + k] * vel;
        if (it.keys[KEY_RIGHT]) acc += cam_basis[3 + k] * vel;
        if (it.keys[KEY_UP])    acc += cam_basis[6 + k] * vel;
        if (it.keys[KEY_DOWN])  acc -= cam_basis[6 + k] * vel;
        np = cam_pos[k] + round_shift(acc, 30);
        if (np > 64'sd2147483647) np = 64'sd2147483647;
        if (np < -64'sd2147483648) np = -64'sd2147483648;
        cam_pos[k] = np;
      end
    end
    rebuild_cam_basis();
    for (int k = 0; k < 9; k++) p.vec[k] = cam_basis[k][15:0];
    for (int k = 0; k < 3; k++) p.pos[k] = cam_pos[k][31:0];
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item and record the pose it should produce
  task automatic send_item(input cam_item_t it);
    pose_t p;
    repeat (pick_gap(calm_src)) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.mode;
    s_axis_tdata  = {it.tstep, it.boost, it.keys, it.clamp, it.dy, it.dx};
    do @(posedge clk); while (!s_axis_tready);
    advance_pose(it, p);
    if (it.pos_at_origin) begin
      for (int k = 0; k < 3; k++) p.pos[k] = '0;
    end
    pending_poses.push_back(p);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Register writes only once the unit has drained
  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait (pending_poses.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_MOVE_SPEED) speed_q8 = val;
    else sens_q16 = val;
  endtask

  function automatic cam_item_t random_item();
    cam_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.mode  = mode_t'($urandom_range(0, 1));
    it.dx    = $urandom;
    it.dy    = $urandom;
    it.clamp = $urandom_range(0, 1);
    it.keys  = $urandom;
    it.boost = $urandom_range(0, 1);
    it.tstep = $urandom;
    it.pos_at_origin = 1'b0;
    // Mostly modest mouse moves so the angles walk through every quadrant
    if (r < 45) begin
      it.dx = $signed($urandom_range(0, 800)) - 400;
      it.dy = $signed($urandom_range(0, 800)) - 400;
    end else if (r < 70) begin
      it.dx = $signed($urandom_range(0, 80)) - 40;
      it.dy = $signed($urandom_range(0, 80)) - 40;
      it.tstep = $urandom_range(0, 4000);
    end
    return it;
  endfunction

  function automatic cam_item_t mk(input mode_t m, input int dx, input int dy,
                                   input bit cl, input logic [5:0] keys,
                                   input bit bo, input int ts, input bit origin);
    cam_item_t it;
    it.mode = m; it.dx = dx; it.dy = dy; it.clamp = cl; it.keys = keys;
    it.boost = bo; it.tstep = ts; it.pos_at_origin = origin;
    return it;
  endfunction

  // Idle and stall the result side
  always @(negedge clk) begin
    if (m_axis_tready && !calm_sink && $urandom_range(0, 99) < 30) begin
      m_axis_tready <= 1'b0;
    end else if (!m_axis_tready && (calm_sink || pick_gap(1'b0) == 0)) begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest pending pose
  always @(posedge clk) begin
    pose_t e;
    logic signed [15:0] got16;
    logic signed [31:0] got32;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_poses.size() == 0) begin
        $error("result transaction with no pending pose");
        fail_count++;
      end else begin
        e = pending_poses.pop_front();
        for (int k = 0; k < 9; k++) begin
          got16 = m_axis_tdata[16*k +: 16];
          if (got16 !== e.vec[k]) begin
            $error("%s: expected %0d, got %0d", vec_names[k], e.vec[k], got16);
            fail_count++;
          end
        end
        for (int k = 0; k < 3; k++) begin
          got32 = m_axis_tdata[144 + 32*k +: 32];
          if (got32 !== e.pos[k]) begin
            $error("%s: expected %0d, got %0d", pos_names[k], e.pos[k], got32);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cam_item_t directed [$];
    int n;
    speed_q8 = 640;
    sens_q16 = 6554;
    yaw_ang = 0;
    pitch_ang = 0;
    for (int k = 0; k < 3; k++) cam_pos[k] = 0;
    rebuild_cam_basis();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: extremes, each key, opposite keys, vertical and over-the-top pitch
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'h3f, 1, 0, 1));
    directed.push_back(mk(MODE_MOVE, -1, -1, 1, 6'h00, 1, 65535, 1));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b000011, 1, 65535, 1));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b001100, 0, 65535, 1));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b110000, 1, 65535, 1));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b000001, 1, 65535, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b000010, 0, 65535, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b000100, 0, 40000, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b001000, 1, 1, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b010000, 0, 32768, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b100000, 1, 12345, 0));
    directed.push_back(mk(MODE_LOOK, 0, 900, 0, 6'h3f, 1, 65535, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b111111, 1, 65535, 0));
    directed.push_back(mk(MODE_LOOK, 0, 100, 0, 6'h00, 0, 0, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b001001, 1, 50000, 0));
    directed.push_back(mk(MODE_LOOK, 1800, -1000, 1, 6'h00, 0, 0, 0));
    directed.push_back(mk(MODE_LOOK, 32767, 32767, 1, 6'h00, 0, 0, 0));
    directed.push_back(mk(MODE_LOOK, -32768, -32768, 0, 6'h00, 0, 0, 0));
    directed.push_back(mk(MODE_LOOK, 32767, -32768, 1, 6'h00, 0, 0, 0));
    directed.push_back(mk(MODE_LOOK, -900, 1790, 1, 6'h00, 0, 0, 0));
    directed.push_back(mk(MODE_MOVE, 0, 0, 0, 6'b010101, 0, 65535, 0));
    foreach (directed[i]) send_item(directed[i]);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_MOVE_SPEED, 16'hffff); write_reg(REG_LOOK_SENS, 16'hffff); end
        1: begin write_reg(REG_MOVE_SPEED, 16'h0000); write_reg(REG_LOOK_SENS, 16'h0000); end
        2: begin write_reg(REG_MOVE_SPEED, $urandom); write_reg(REG_LOOK_SENS, $urandom); end
        3: begin write_reg(REG_MOVE_SPEED, 16'h0001); write_reg(REG_LOOK_SENS, 16'h0001); end
        default: begin
          write_reg(REG_MOVE_SPEED, 16'd640);
          write_reg(REG_LOOK_SENS, 16'd6554);
        end
      endcase
      n = (ph == 4) ? 520 : 270;
      for (int i = 0; i < n; i++) begin
        if (i % 64 == 0) begin
          calm_src  = ($urandom_range(0, 3) == 0);
          calm_sink = ($urandom_range(0, 3) == 0);
        end
        send_item(random_item());
      end
    end

    wait (pending_poses.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/epu_pkg.sv
src/epu_mul.sv
src/epu_cordic.sv
src/euler_camera_pose_update.sv
sim/euler_camera_pose_update_test.sv
